### design/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, muted while reset is asserted.
`define ASSERT_IMPLY(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after reset is sampled low.
`define ASSERT_AFTER_RESET(name, clk, rstn, cons, msg) \
    name: assert property (@(posedge clk) !(rstn) |=> (cons)) else $error(msg);

`endif

### design/ptc_pkg.sv
package ptc_pkg;

    // Raw reading and result widths
    localparam int RAW_W      = 24;
    localparam int COEF_W     = 16;
    localparam int TEMP_W     = 19;
    localparam int PRES_W     = 21;
    localparam int CFG_INDEX_W = 3;

    // Pipeline depth, accept to result
    localparam int NUM_STAGES = 8;

    // Temperature origin, hundredths of a degree
    localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;

    // Divide by ten as multiply by ceil(2^29/10) and shift right by 29
    localparam logic [25:0] DIV10_RECIP = 26'd53687092;
    localparam int          DIV10_SHIFT = 29;

    // Pressure saturation limits
    localparam logic signed [PRES_W-1:0] PRES_MAX = {1'b0, {(PRES_W-1){1'b1}}};
    localparam logic signed [PRES_W-1:0] PRES_MIN = {1'b1, {(PRES_W-1){1'b0}}};
    localparam logic [21:0] PRES_POS_LIMIT = 22'd1048575;
    localparam logic [21:0] PRES_NEG_LIMIT = 22'd1048576;

    // Calibration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SENS_BASE     = 3'd0,
        CFG_OFFSET_BASE   = 3'd1,
        CFG_SENS_TEMPCO   = 3'd2,
        CFG_OFFSET_TEMPCO = 3'd3,
        CFG_REF_TEMP      = 3'd4,
        CFG_TEMP_SLOPE    = 3'd5
    } cfg_index_t;

    // Calibration coefficient set
    typedef struct packed {
        logic [COEF_W-1:0] sens_base;
        logic [COEF_W-1:0] offset_base;
        logic [COEF_W-1:0] sens_tempco;
        logic [COEF_W-1:0] offset_tempco;
        logic [COEF_W-1:0] ref_temp;
        logic [COEF_W-1:0] temp_slope;
    } cal_t;

endpackage

### design/ptc_pipe.sv
module ptc_pipe import ptc_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [RAW_W-1:0]         in_pressure,
    input  logic [RAW_W-1:0]         in_temperature,
    input  cal_t                     cal,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [TEMP_W-1:0] out_temperature,
    output logic signed [PRES_W-1:0] out_pressure
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_ready;

    // Stage 0: temperature difference
    logic [RAW_W-1:0]    d1_s0_reg;
    logic signed [24:0]  dt_s0_reg, dt_s0_next;
    // Stage 1: coefficient products
    logic [RAW_W-1:0]    d1_s1_reg;
    logic signed [41:0]  prod_temp_s1_reg, prod_temp_s1_next;
    logic signed [41:0]  prod_off_s1_reg, prod_off_s1_next;
    logic signed [41:0]  prod_sens_s1_reg, prod_sens_s1_next;
    // Stage 2: temperature, offset, sensitivity
    logic [RAW_W-1:0]    d1_s2_reg;
    logic signed [TEMP_W-1:0] temp_s2_reg, temp_s2_next;
    logic signed [35:0]  off_s2_reg, off_s2_next;
    logic signed [33:0]  sens_s2_reg, sens_s2_next;
    logic signed [41:0]  temp_bias, temp_sum;
    logic signed [41:0]  off_bias, off_sum;
    logic signed [41:0]  sens_bias, sens_sum;
    // Stage 3: split sensitivity product
    logic signed [TEMP_W-1:0] temp_s3_reg;
    logic signed [35:0]  off_s3_reg;
    logic [40:0]         sens_lo_s3_reg, sens_lo_s3_next;
    logic signed [41:0]  sens_hi_s3_reg, sens_hi_s3_next;
    // Stage 4: numerator
    logic signed [TEMP_W-1:0] temp_s4_reg;
    logic signed [59:0]  num_s4_reg, num_s4_next;
    // Stage 5: magnitude of the quotient by 2^34
    logic signed [TEMP_W-1:0] temp_s5_reg;
    logic [24:0]         mag_s5_reg, mag_s5_next;
    logic                neg_s5_reg;
    logic [25:0]         num_floor, mag_full;
    logic                frac_zero;
    // Stage 6: reciprocal product
    logic signed [TEMP_W-1:0] temp_s6_reg;
    logic [50:0]         quot_prod_s6_reg, quot_prod_s6_next;
    logic                neg_s6_reg;
    // Stage 7: output word
    logic signed [TEMP_W-1:0] temp_s7_reg;
    logic signed [PRES_W-1:0] pres_s7_reg, pres_s7_next;
    logic [21:0]         quot;
    logic [22:0]         quot_neg;

    // A stage takes a new word when empty or when its word moves on
    always_comb begin
        stage_ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
        valid_next[0] = stage_ready[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            valid_next[k] = stage_ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Stage 0
    assign dt_s0_next = $signed({1'b0, in_temperature}) - $signed({1'b0, cal.ref_temp, 8'h00});

    // Stage 1
    always_comb begin
        prod_temp_s1_next = dt_s0_reg * $signed({1'b0, cal.temp_slope});
        prod_off_s1_next  = dt_s0_reg * $signed({1'b0, cal.offset_tempco});
        prod_sens_s1_next = dt_s0_reg * $signed({1'b0, cal.sens_tempco});
    end

    // Stage 2: shifts rounded toward zero, then base terms
    always_comb begin
        temp_bias = prod_temp_s1_reg[41] ? 42'sd8388607 : 42'sd0;
        off_bias  = prod_off_s1_reg[41]  ? 42'sd127     : 42'sd0;
        sens_bias = prod_sens_s1_reg[41] ? 42'sd255     : 42'sd0;
        temp_sum  = prod_temp_s1_reg + temp_bias;
        off_sum   = prod_off_s1_reg + off_bias;
        sens_sum  = prod_sens_s1_reg + sens_bias;
        temp_s2_next = $signed(temp_sum[41:23]) + TEMP_BASE;
        off_s2_next  = $signed({4'd0, cal.offset_base, 16'd0})
                     + $signed({off_sum[41], off_sum[41:7]});
        sens_s2_next = $signed({3'd0, cal.sens_base, 15'd0}) + $signed(sens_sum[41:8]);
    end

    // Stage 3: D1 times low and high halves of the sensitivity
    always_comb begin
        sens_lo_s3_next = d1_s2_reg * sens_s2_reg[16:0];
        sens_hi_s3_next = $signed({1'b0, d1_s2_reg}) * $signed(sens_s2_reg[33:17]);
    end

    // Stage 4: D1*SENS - OFF*2^21
    assign num_s4_next = $signed({sens_hi_s3_reg[41], sens_hi_s3_reg, 17'd0})
                       + $signed({19'd0, sens_lo_s3_reg})
                       - $signed({{3{off_s3_reg[35]}}, off_s3_reg, 21'd0});

    // Stage 5: |trunc(num / 2^34)|
    always_comb begin
        num_floor = num_s4_reg[59:34];
        frac_zero = (num_s4_reg[33:0] == 34'd0);
        mag_full  = num_s4_reg[59] ? (~num_floor + {25'd0, frac_zero}) : num_floor;
        mag_s5_next = mag_full[24:0];
    end

    // Stage 6
    assign quot_prod_s6_next = mag_s5_reg * DIV10_RECIP;

    // Stage 7: restore sign and saturate
    always_comb begin
        quot     = quot_prod_s6_reg[DIV10_SHIFT +: 22];
        quot_neg = 23'd0 - {1'b0, quot};
        if (neg_s6_reg) begin
            pres_s7_next = (quot > PRES_NEG_LIMIT) ? PRES_MIN : $signed(quot_neg[PRES_W-1:0]);
        end else begin
            pres_s7_next = (quot > PRES_POS_LIMIT) ? PRES_MAX : $signed(quot[PRES_W-1:0]);
        end
    end

    // Advance payload where the stage takes a word
    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            d1_s0_reg <= in_pressure;
            dt_s0_reg <= dt_s0_next;
        end
        if (stage_ready[1]) begin
            d1_s1_reg        <= d1_s0_reg;
            prod_temp_s1_reg <= prod_temp_s1_next;
            prod_off_s1_reg  <= prod_off_s1_next;
            prod_sens_s1_reg <= prod_sens_s1_next;
        end
        if (stage_ready[2]) begin
            d1_s2_reg   <= d1_s1_reg;
            temp_s2_reg <= temp_s2_next;
            off_s2_reg  <= off_s2_next;
            sens_s2_reg <= sens_s2_next;
        end
        if (stage_ready[3]) begin
            temp_s3_reg    <= temp_s2_reg;
            off_s3_reg     <= off_s2_reg;
            sens_lo_s3_reg <= sens_lo_s3_next;
            sens_hi_s3_reg <= sens_hi_s3_next;
        end
        if (stage_ready[4]) begin
            temp_s4_reg <= temp_s3_reg;
            num_s4_reg  <= num_s4_next;
        end
        if (stage_ready[5]) begin
            temp_s5_reg <= temp_s4_reg;
            mag_s5_reg  <= mag_s5_next;
            neg_s5_reg  <= num_s4_reg[59];
        end
        if (stage_ready[6]) begin
            temp_s6_reg      <= temp_s5_reg;
            quot_prod_s6_reg <= quot_prod_s6_next;
            neg_s6_reg       <= neg_s5_reg;
        end
        if (stage_ready[7]) begin
            temp_s7_reg <= temp_s6_reg;
            pres_s7_reg <= pres_s7_next;
        end
    end

    assign in_ready        = stage_ready[0];
    assign out_valid       = valid_reg[NUM_STAGES-1];
    assign out_temperature = temp_s7_reg;
    assign out_pressure    = pres_s7_reg;

endmodule

### design/pressure_temperature_compensation.sv
// First-order compensation of a barometric pressure/temperature sensor.
// Input stream (s_): one word per reading pair, raw pressure D1 and raw
// temperature D2. Output stream (m_): one word per input word, temperature
// in hundredths of a degree and pressure in millibar, both two's complement.
// Configuration channel (cfg_): writes the six calibration coefficients,
// index 0..5 as C1..C6; other indexes are ignored. cfg_ready is always high.
// Write coefficients only while no word is in flight.
// An accepted word is registered in stages 0 to 7 in turn; m_tvalid is
// the valid bit of stage 7. One word is taken per cycle while m_tready
// does not stall the output, by an eight-stage pipeline whose widest
// steps are the 25x26 reciprocal multiplier and the 60-bit numerator adder.
// The last stage is the output register; each stage holds its word while
// the one after it holds, so m_tready low fills the pipeline up to eight
// words before s_tready falls, and bubbles close up. Nothing is dropped.
// Pressure outside the 21-bit range saturates.
// Reset (aresetn low, synchronous) empties the pipeline and clears all
// coefficients to zero.
module pressure_temperature_compensation import ptc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [47:0]            s_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
    // Result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [39:0]            m_tdata,   // [18:0] temperature_centi, [39:19] pressure_mbar
    // Configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]      cfg_data
);

`include "assert_macros.svh"

    cal_t cal_reg, cal_next;
    logic signed [TEMP_W-1:0] temperature_centi;
    logic signed [PRES_W-1:0] pressure_mbar;

    assign cfg_ready = 1'b1;

    // Decode coefficient writes
    always_comb begin
        cal_next = cal_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SENS_BASE:     cal_next.sens_base     = cfg_data;
                CFG_OFFSET_BASE:   cal_next.offset_base   = cfg_data;
                CFG_SENS_TEMPCO:   cal_next.sens_tempco   = cfg_data;
                CFG_OFFSET_TEMPCO: cal_next.offset_tempco = cfg_data;
                CFG_REF_TEMP:      cal_next.ref_temp      = cfg_data;
                CFG_TEMP_SLOPE:    cal_next.temp_slope    = cfg_data;
                default:           cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else begin
            cal_reg <= cal_next;
        end
    end

    ptc_pipe u_pipe (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_pressure     (s_tdata[23:0]),
        .in_temperature  (s_tdata[47:24]),
        .cal             (cal_reg),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_temperature (temperature_centi),
        .out_pressure    (pressure_mbar)
    );

    assign m_tdata = {pressure_mbar, temperature_centi};

    // Checks
    `ASSERT_AFTER_RESET(a_reset_empty, aclk, aresetn, !m_tvalid, "result valid right after reset")
    `ASSERT_IMPLY(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready, "input stalled with empty output")
    `ASSERT_IMPLY(a_temp_range, aclk, aresetn, m_tvalid, ($signed(m_tdata[18:0]) >= -19'sd129072) && ($signed(m_tdata[18:0]) <= 19'sd133071), "temperature out of range")

endmodule
